FILE: sv/alu8080_pkg.sv
// Package for the 8080-style accumulator ALU: transaction structs,
// operation codes and flag bit positions.
// Used by alu8080_core, alu8080_flag_unit_top and alu8080_checker.
package alu8080_pkg;

    typedef logic [4:0] func_t;

    localparam func_t FUNC_ADD = 5'd0;
    localparam func_t FUNC_ADC = 5'd1;
    localparam func_t FUNC_SUB = 5'd2;
    localparam func_t FUNC_SBB = 5'd3;
    localparam func_t FUNC_ANA = 5'd4;
    localparam func_t FUNC_XRA = 5'd5;
    localparam func_t FUNC_ORA = 5'd6;
    localparam func_t FUNC_CMP = 5'd7;
    localparam func_t FUNC_INR = 5'd8;
    localparam func_t FUNC_DCR = 5'd9;
    localparam func_t FUNC_RLC = 5'd10;
    localparam func_t FUNC_RRC = 5'd11;
    localparam func_t FUNC_RAL = 5'd12;
    localparam func_t FUNC_RAR = 5'd13;
    localparam func_t FUNC_DAA = 5'd14;
    localparam func_t FUNC_CMA = 5'd15;
    localparam func_t FUNC_STC = 5'd16;
    localparam func_t FUNC_CMC = 5'd17;

    // Bit positions within the flag byte.
    localparam int FLAG_CY = 0;
    localparam int FLAG_P  = 2;
    localparam int FLAG_AC = 4;
    localparam int FLAG_Z  = 6;
    localparam int FLAG_S  = 7;

    typedef struct packed {
        func_t      func;
        logic [7:0] acc;
        logic [7:0] operand;
        logic [7:0] flags_in;
    } cmd_t;

    typedef struct packed {
        logic [7:0] result;
        logic [7:0] flags_out;
        logic       writes_back;
    } res_t;

endpackage

FILE: sv/alu8080_core.sv
// Combinational datapath of the 8080-style ALU: one shared 8-bit adder,
// the logic operations, rotates, decimal adjust and the flag update.
// Depends on alu8080_pkg.
module alu8080_core (
    input  alu8080_pkg::cmd_t cmd,
    output alu8080_pkg::res_t res
);
    import alu8080_pkg::*;

    logic       cy;
    logic [3:0] lo_nib;
    logic [3:0] hi_nib;
    logic       daa_lo;
    logic       daa_hi;
    logic [7:0] daa_corr;
    logic [7:0] add_b;
    logic       add_cin;
    logic [8:0] add_sum;
    logic [4:0] nib_sum;
    logic       add_ac;
    logic [7:0] r;
    logic [7:0] f;
    logic       wb;

    assign cy     = cmd.flags_in[FLAG_CY];
    assign lo_nib = cmd.acc[3:0];
    assign hi_nib = cmd.acc[7:4];

    // Decimal adjust: the low correction follows AC or a low digit above nine,
    // the high one follows carry or a high digit that overflows.
    assign daa_lo   = cmd.flags_in[FLAG_AC] || (lo_nib > 4'd9);
    assign daa_hi   = cy || (hi_nib > 4'd9) || ((hi_nib >= 4'd9) && (lo_nib > 4'd9));
    assign daa_corr = {1'b0, daa_hi, daa_hi, 1'b0, 1'b0, daa_lo, daa_lo, 1'b0};

    // Operand selection for the shared adder; subtraction is A + ~B + 1.
    always_comb
    begin
        add_b   = cmd.operand;
        add_cin = 1'b0;
        case (cmd.func)
            FUNC_ADC:
            begin
                add_cin = cy;
            end
            FUNC_SUB, FUNC_CMP:
            begin
                add_b   = ~cmd.operand;
                add_cin = 1'b1;
            end
            FUNC_SBB:
            begin
                add_b   = ~cmd.operand;
                add_cin = ~cy;
            end
            FUNC_INR:
            begin
                add_b = 8'h01;
            end
            FUNC_DCR:
            begin
                add_b   = 8'hFE;
                add_cin = 1'b1;
            end
            FUNC_DAA:
            begin
                add_b = daa_corr;
            end
            default:
            begin
                add_b   = cmd.operand;
                add_cin = 1'b0;
            end
        endcase
    end

    assign add_sum = {1'b0, cmd.acc} + {1'b0, add_b} + {8'd0, add_cin};
    assign nib_sum = {1'b0, cmd.acc[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};
    assign add_ac  = nib_sum[4];

    always_comb
    begin
        r  = cmd.acc;
        f  = cmd.flags_in;
        wb = 1'b1;
        unique case (cmd.func)
            FUNC_ADD, FUNC_ADC:
            begin
                r          = add_sum[7:0];
                f[FLAG_AC] = add_ac;
                f[FLAG_CY] = add_sum[8];
            end
            FUNC_SUB, FUNC_SBB, FUNC_CMP:
            begin
                r          = add_sum[7:0];
                f[FLAG_AC] = add_ac;
                f[FLAG_CY] = ~add_sum[8];
            end
            FUNC_ANA:
            begin
                r          = cmd.acc & cmd.operand;
                f[FLAG_AC] = cmd.acc[3] | cmd.operand[3];
                f[FLAG_CY] = 1'b0;
            end
            FUNC_XRA:
            begin
                r          = cmd.acc ^ cmd.operand;
                f[FLAG_AC] = 1'b0;
                f[FLAG_CY] = 1'b0;
            end
            FUNC_ORA:
            begin
                r          = cmd.acc | cmd.operand;
                f[FLAG_AC] = 1'b0;
                f[FLAG_CY] = 1'b0;
            end
            FUNC_INR, FUNC_DCR:
            begin
                r          = add_sum[7:0];
                f[FLAG_AC] = add_ac;
            end
            FUNC_RLC:
            begin
                r          = {cmd.acc[6:0], cmd.acc[7]};
                f[FLAG_CY] = cmd.acc[7];
            end
            FUNC_RRC:
            begin
                r          = {cmd.acc[0], cmd.acc[7:1]};
                f[FLAG_CY] = cmd.acc[0];
            end
            FUNC_RAL:
            begin
                r          = {cmd.acc[6:0], cy};
                f[FLAG_CY] = cmd.acc[7];
            end
            FUNC_RAR:
            begin
                r          = {cy, cmd.acc[7:1]};
                f[FLAG_CY] = cmd.acc[0];
            end
            FUNC_DAA:
            begin
                r          = add_sum[7:0];
                f[FLAG_AC] = add_ac;
                f[FLAG_CY] = daa_hi;
            end
            FUNC_CMA:
            begin
                r = ~cmd.acc;
            end
            FUNC_STC:
            begin
                f[FLAG_CY] = 1'b1;
                wb         = 1'b0;
            end
            FUNC_CMC:
            begin
                f[FLAG_CY] = ~cy;
                wb         = 1'b0;
            end
            default:
            begin
                wb = 1'b0;
            end
        endcase

        // Add, subtract, compare, the logic operations, INR, DCR and DAA refresh sign, zero and parity.
        if ((cmd.func <= FUNC_DCR) || (cmd.func == FUNC_DAA))
        begin
            f[FLAG_S] = r[7];
            f[FLAG_Z] = (r == 8'd0);
            f[FLAG_P] = ~^r;
        end

        // Compare sets the flags but leaves the accumulator alone.
        if (cmd.func == FUNC_CMP)
        begin
            r  = cmd.acc;
            wb = 1'b0;
        end
    end

    assign res.result      = r;
    assign res.flags_out   = f;
    assign res.writes_back = wb;

endmodule

FILE: sv/alu8080_flag_unit_top.sv
// Top level of the 8080-style ALU: input register, ALU datapath and
// result register with valid/stall handshakes on both sides.
// Depends on alu8080_pkg and alu8080_core.
//
//   Channel | Ports                        | Payload
//   --------+------------------------------+-----------------------------------
//   command | cmd_valid, cmd_stall, cmd    | func, acc, operand, flags_in
//   result  | res_valid, res_stall, res    | result, flags_out, writes_back
//
// One transaction is accepted per cycle while cmd_stall is low; an accepted command
// is captured in the input register, and its result is loaded into the result
// register, which drives the port, once that register is free or being taken.
// The ALU itself is a single pass of logic between those two registers.
// Reset clears both valid flags; the data registers are not reset.
// A stall on the result side holds a full result register, and the command side
// stalls only while both registers are full and the result is not taken.
module alu8080_flag_unit_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  alu8080_pkg::cmd_t cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output alu8080_pkg::res_t res
);
    import alu8080_pkg::*;

    logic in_valid_reg;
    logic in_valid_next;
    cmd_t in_reg;
    logic out_valid_reg;
    logic out_valid_next;
    res_t out_reg;
    res_t alu_res;
    logic out_load;
    logic in_load;

    alu8080_core u_core (
        .cmd (in_reg),
        .res (alu_res)
    );

    assign out_load = !out_valid_reg || !res_stall;
    assign in_load  = !in_valid_reg || out_load;

    assign in_valid_next  = in_load ? cmd_valid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load && cmd_valid)
        begin
            in_reg <= cmd;
        end
        if (out_load && in_valid_reg)
        begin
            out_reg <= alu_res;
        end
    end

    assign cmd_stall = !in_load;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

FILE: sv/alu8080_checker.sv
// Port-level assertions for alu8080_flag_unit_top, attached by the bind below.
// Depends on alu8080_pkg.
module alu8080_flag_unit_assert (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input alu8080_pkg::cmd_t cmd,
    input logic              res_valid,
    input logic              res_stall,
    input alu8080_pkg::res_t res
);
    import alu8080_pkg::*;

    // A result that is held back stays on the port unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // The command side only stalls when the result side is full and blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid && res_stall)
        else $error("command stalled without a blocked result");

    // Set carry reaches the output with no write-back if the result side does not stall.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && cmd.func == FUNC_STC) ##1 !res_stall
        |=> res_valid && !res.writes_back && res.flags_out[FLAG_CY])
        else $error("STC result wrong or late");

    // Complement writes back the inverted accumulator, flags untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && cmd.func == FUNC_CMA) ##1 !res_stall
        |=> res_valid && res.writes_back && res.result == ~$past(cmd.acc, 2)
            && res.flags_out == $past(cmd.flags_in, 2))
        else $error("CMA result wrong or late");

endmodule

bind alu8080_flag_unit_top alu8080_flag_unit_assert u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
);

FILE: dv/alu8080_checker.sv
// Checker for the 8080-style ALU: watches both channels, predicts each result
// from the accepted command and compares it field by field.
// Depends on alu8080_pkg for the transaction structs, operation codes and flag bits.
module alu8080_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  alu8080_pkg::cmd_t cmd,
    input  logic              res_valid,
    input  logic              res_stall,
    input  alu8080_pkg::res_t res,
    output int                fail_count,
    output int                pending
);

    import alu8080_pkg::*;

    typedef struct {
        cmd_t issued;
        res_t want;
    } alu_expect_t;

    alu_expect_t expected_q[$];

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // Adds a + b + cin over nine bits and gives the carry out of bit 3.
    function automatic logic [8:0] add_bytes(input logic [7:0] a, input logic [7:0] b,
                                             input logic cin, output logic half);
        logic [4:0] nibble;
        nibble = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
        half   = nibble[4];
        return {1'b0, a} + {1'b0, b} + {8'd0, cin};
    endfunction

    function automatic logic [7:0] with_szp(input logic [7:0] fl, input logic [7:0] v);
        logic [7:0] f;
        f          = fl;
        f[FLAG_S]  = v[7];
        f[FLAG_Z]  = (v == 8'h00);
        f[FLAG_P]  = ~^v;
        return f;
    endfunction

    function automatic res_t predict_alu(input cmd_t c);
        res_t       r;
        logic [8:0] sum;
        logic [7:0] fl;
        logic [7:0] corr;
        logic       half;
        logic       cy;
        logic       new_cy;
        fl            = c.flags_in;
        cy            = fl[FLAG_CY];
        r.result      = c.acc;
        r.writes_back = 1'b1;
        half          = 1'b0;
        case (c.func)
            FUNC_ADD, FUNC_ADC:
            begin
                sum         = add_bytes(c.acc, c.operand, (c.func == FUNC_ADC) && cy, half);
                r.result    = sum[7:0];
                fl          = with_szp(fl, sum[7:0]);
                fl[FLAG_AC] = half;
                fl[FLAG_CY] = sum[8];
            end
            FUNC_SUB, FUNC_SBB, FUNC_CMP:
            begin
                // Subtraction runs through the adder as acc + ~operand + 1, with
                // the borrow taken in as a missing carry for SBB.
                sum         = add_bytes(c.acc, ~c.operand, !((c.func == FUNC_SBB) && cy),
                                        half);
                r.result    = sum[7:0];
                fl          = with_szp(fl, sum[7:0]);
                fl[FLAG_AC] = half;
                fl[FLAG_CY] = ~sum[8];
                if (c.func == FUNC_CMP)
                begin
                    r.result      = c.acc;
                    r.writes_back = 1'b0;
                end
            end
            FUNC_ANA:
            begin
                r.result    = c.acc & c.operand;
                fl          = with_szp(fl, r.result);
                fl[FLAG_AC] = c.acc[3] | c.operand[3];
                fl[FLAG_CY] = 1'b0;
            end
            FUNC_XRA, FUNC_ORA:
            begin
                r.result    = (c.func == FUNC_XRA) ? (c.acc ^ c.operand)
                                                   : (c.acc | c.operand);
                fl          = with_szp(fl, r.result);
                fl[FLAG_AC] = 1'b0;
                fl[FLAG_CY] = 1'b0;
            end
            FUNC_INR, FUNC_DCR:
            begin
                if (c.func == FUNC_INR)
                    sum = add_bytes(c.acc, 8'h01, 1'b0, half);
                else
                    sum = add_bytes(c.acc, 8'hFE, 1'b1, half);
                r.result    = sum[7:0];
                fl          = with_szp(fl, sum[7:0]);
                fl[FLAG_AC] = half;
            end
            FUNC_RLC:
            begin
                r.result    = {c.acc[6:0], c.acc[7]};
                fl[FLAG_CY] = c.acc[7];
            end
            FUNC_RRC:
            begin
                r.result    = {c.acc[0], c.acc[7:1]};
                fl[FLAG_CY] = c.acc[0];
            end
            FUNC_RAL:
            begin
                r.result    = {c.acc[6:0], cy};
                fl[FLAG_CY] = c.acc[7];
            end
            FUNC_RAR:
            begin
                r.result    = {cy, c.acc[7:1]};
                fl[FLAG_CY] = c.acc[0];
            end
            FUNC_DAA:
            begin
                corr   = 8'h00;
                new_cy = cy;
                if (fl[FLAG_AC] || c.acc[3:0] > 4'd9)
                    corr[3:0] = 4'h6;
                if (cy || c.acc[7:4] > 4'd9 || (c.acc[7:4] >= 4'd9 && c.acc[3:0] > 4'd9))
                begin
                    corr[7:4] = 4'h6;
                    new_cy    = 1'b1;
                end
                sum         = add_bytes(c.acc, corr, 1'b0, half);
                r.result    = sum[7:0];
                fl          = with_szp(fl, sum[7:0]);
                fl[FLAG_AC] = half;
                fl[FLAG_CY] = new_cy;
            end
            FUNC_CMA:
            begin
                r.result = ~c.acc;
            end
            FUNC_STC:
            begin
                fl[FLAG_CY]   = 1'b1;
                r.writes_back = 1'b0;
            end
            FUNC_CMC:
            begin
                fl[FLAG_CY]   = ~cy;
                r.writes_back = 1'b0;
            end
            default:
            begin
                r.writes_back = 1'b0;
            end
        endcase
        r.flags_out = fl;
        return r;
    endfunction

    always @(posedge clk)
    begin
        alu_expect_t e;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                e.issued = cmd;
                e.want   = predict_alu(cmd);
                expected_q.push_back(e);
            end
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch($sformatf("result %h flags %h wb %b with nothing expected",
                                              res.result, res.flags_out, res.writes_back));
                else
                begin
                    e = expected_q.pop_front();
                    if (res.result !== e.want.result)
                        report_mismatch($sformatf("func %0d acc %h op %h fl %h: result %h, want %h",
                                                  e.issued.func, e.issued.acc, e.issued.operand,
                                                  e.issued.flags_in, res.result, e.want.result));
                    if (res.flags_out !== e.want.flags_out)
                        report_mismatch($sformatf("func %0d acc %h op %h fl %h: flags %h, want %h",
                                                  e.issued.func, e.issued.acc, e.issued.operand,
                                                  e.issued.flags_in, res.flags_out,
                                                  e.want.flags_out));
                    if (res.writes_back !== e.want.writes_back)
                        report_mismatch($sformatf("func %0d acc %h op %h fl %h: wb %b, want %b",
                                                  e.issued.func, e.issued.acc, e.issued.operand,
                                                  e.issued.flags_in, res.writes_back,
                                                  e.want.writes_back));
                end
            end
            pending <= expected_q.size();
        end
    end

endmodule

FILE: dv/tb_alu8080_flag_unit_top.sv
// Testbench top for the 8080-style ALU: clock, reset, command stimulus and
// result-side stalls, with the verdict taken from alu8080_checker.
// Depends on alu8080_pkg, alu8080_flag_unit_top and alu8080_checker.
module tb_alu8080_flag_unit_top;

    import alu8080_pkg::*;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;
    logic hold_off = 1'b0;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   fail_count;
    int   pending;

    alu8080_flag_unit_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    alu8080_checker u_alu_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Result side: random stalls, or a solid stall while a hold-off is running.
    initial
    begin
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_stall <= hold_off || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    task automatic hold_receiver(input int cycles);
        hold_off <= 1'b1;
        repeat (cycles) @(posedge clk);
        hold_off <= 1'b0;
    endtask

    // Called just after a rising edge; returns at the edge that accepted the
    // transaction.
    task automatic send_cmd(input cmd_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    function automatic cmd_t make_cmd(input func_t f, input logic [7:0] a,
                                      input logic [7:0] b, input logic [7:0] fl);
        cmd_t c;
        c.func     = f;
        c.acc      = a;
        c.operand  = b;
        c.flags_in = fl;
        return c;
    endfunction

    // Bytes lean towards the two extremes now and then.
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_random(input int count);
        func_t f;
        for (int i = 0; i < count; i++)
        begin
            // Unused codes are legal input, so a tenth of the traffic uses them.
            if ($urandom_range(0, 9) == 0)
                f = func_t'($urandom_range(18, 31));
            else
                f = func_t'($urandom_range(FUNC_ADD, FUNC_CMC));
            send_cmd(make_cmd(f, pick_byte(), pick_byte(), pick_byte()));
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cmd_valid    <= 1'b0;
        cmd          <= '0;
        send_idle_pct = 30;
        recv_idle_pct = 72;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed transactions: field extremes, every operation, the DAA
        // corrections and the unused codes.
        send_cmd(make_cmd(FUNC_ADD, 8'hFF, 8'h01, 8'h00));
        send_cmd(make_cmd(FUNC_ADC, 8'hFF, 8'h00, 8'hFF));
        send_cmd(make_cmd(FUNC_SUB, 8'h00, 8'h01, 8'h00));
        send_cmd(make_cmd(FUNC_SBB, 8'h00, 8'hFF, 8'h01));
        send_cmd(make_cmd(FUNC_SBB, 8'h80, 8'h7F, 8'h00));
        send_cmd(make_cmd(FUNC_ANA, 8'h08, 8'h00, 8'hFF));
        send_cmd(make_cmd(FUNC_XRA, 8'hAA, 8'h55, 8'hFF));
        send_cmd(make_cmd(FUNC_ORA, 8'h00, 8'h00, 8'hFF));
        send_cmd(make_cmd(FUNC_CMP, 8'h55, 8'h55, 8'h00));
        send_cmd(make_cmd(FUNC_INR, 8'hFF, 8'h00, 8'h01));
        send_cmd(make_cmd(FUNC_INR, 8'h0F, 8'hFF, 8'h00));
        send_cmd(make_cmd(FUNC_DCR, 8'h00, 8'hFF, 8'h00));
        send_cmd(make_cmd(FUNC_RLC, 8'h80, 8'h00, 8'h00));
        send_cmd(make_cmd(FUNC_RRC, 8'h01, 8'h00, 8'h00));
        send_cmd(make_cmd(FUNC_RAL, 8'h7F, 8'h00, 8'h01));
        send_cmd(make_cmd(FUNC_RAR, 8'hFE, 8'h00, 8'h01));
        send_cmd(make_cmd(FUNC_DAA, 8'h9A, 8'h00, 8'h00));
        send_cmd(make_cmd(FUNC_DAA, 8'h15, 8'h00, 8'h10));
        send_cmd(make_cmd(FUNC_DAA, 8'h99, 8'h00, 8'h01));
        send_cmd(make_cmd(FUNC_DAA, 8'hA0, 8'h00, 8'h00));
        send_cmd(make_cmd(FUNC_CMA, 8'h00, 8'hFF, 8'h00));
        send_cmd(make_cmd(FUNC_STC, 8'h3C, 8'h00, 8'h00));
        send_cmd(make_cmd(FUNC_CMC, 8'hC3, 8'hFF, 8'hFF));
        send_cmd(make_cmd(func_t'(18), 8'h12, 8'h34, 8'h56));
        send_cmd(make_cmd(func_t'(31), 8'hFF, 8'hFF, 8'hFF));

        run_random(250);

        send_idle_pct = 72;
        recv_idle_pct = 30;
        run_random(250);

        // No idling from here; a long hold-off on the result side lets the
        // block fill up and push back on the command side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        fork
            hold_receiver(120);
        join_none
        run_random(250);

        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: alu8080_flag_unit_top.f
sv/alu8080_pkg.sv
sv/alu8080_core.sv
sv/alu8080_flag_unit_top.sv
sv/alu8080_checker.sv
dv/alu8080_checker.sv
dv/tb_alu8080_flag_unit_top.sv
